// File: rtl/core/assert_macros.svh
// Assertion macros used by the matcher RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/atrc_pkg.sv
// Package for the AT response code matcher: code table, result codes, result type.
// No dependencies; used by atrc_match and at_response_code_matcher_core.
package atrc_pkg;

	localparam int unsigned BUF_LEN_DEF  = 64;
	localparam int unsigned NUM_CODES    = 8;
	localparam int unsigned MAX_CODE_LEN = 10;
	localparam int unsigned CIW          = $clog2(MAX_CODE_LEN);
	localparam int unsigned LEN_MAX      = 127;

	localparam logic [3:0] CODE_NONE    = 4'd0;
	localparam logic [3:0] CODE_UNKNOWN = 4'd1;
	localparam logic [3:0] CODE_LAST    = 4'd9;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Code text, first character at index 0, padded with NUL.
	localparam logic [7:0] CODE_TEXT [NUM_CODES][MAX_CODE_LEN] = '{
		'{"O", "K", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "P", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "S", "Q", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "M", "E", " ", "E", "R", "R", "O", "R"},
		'{"+", "C", "R", "E", "G", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "E", "R", "E", "G", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"+", "C", "P", "S", "I", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] CODE_LEN [NUM_CODES] = '{
		4'd2, 4'd5, 4'd5, 4'd4, 4'd10, 4'd5, 4'd6, 4'd5
	};

	localparam logic [3:0] CODE_ID [NUM_CODES] = '{
		4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9
	};

	typedef struct packed {
		logic [3:0] code;
		logic [6:0] code_len;
	} atrc_result_t;

endpackage

// File: rtl/core/atrc_match.sv
// Matcher state and per-character update logic: prefix compare, separator skip, result.
// Depends on atrc_pkg.
module atrc_match #(
	parameter int unsigned BUF_LEN = atrc_pkg::BUF_LEN_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  logic [7:0]              ch,
	output logic                    res_valid,
	output atrc_pkg::atrc_result_t  res
);

	localparam int unsigned PW = $clog2(BUF_LEN);
	localparam int unsigned LW = $clog2(BUF_LEN + 1);

	typedef enum logic [1:0] {
		PH_MATCH,
		PH_SKIP,
		PH_TAIL
	} phase_t;

	phase_t                          phase_q, phase_n;
	logic [atrc_pkg::NUM_CODES-1:0]  flags_q, flags_n;
	logic [PW-1:0]                   position_q;
	logic [3:0]                      found_q, found_n;
	logic [LW-1:0]                   plen_q, plen_n;
	logic [atrc_pkg::CIW-1:0]        pos_idx;
	logic                            last;

	assign pos_idx = (position_q < PW'(atrc_pkg::MAX_CODE_LEN)) ?
		position_q[atrc_pkg::CIW-1:0] : '0;
	assign last = (ch == atrc_pkg::CH_NUL) || (position_q == PW'(BUF_LEN - 1));

	always_comb begin
		logic                           hit;
		logic [3:0]                     hit_id;
		logic [atrc_pkg::NUM_CODES-1:0] mism;
		logic [PW-1:0]                  code_len_w;

		hit    = 1'b0;
		hit_id = atrc_pkg::CODE_NONE;
		mism   = '0;
		// Walk downward so the lowest table entry wins a tie.
		for (int i = atrc_pkg::NUM_CODES - 1; i >= 0; i--) begin
			code_len_w = PW'(atrc_pkg::CODE_LEN[i]);
			if (!flags_q[i] && code_len_w == position_q) begin
				hit    = 1'b1;
				hit_id = atrc_pkg::CODE_ID[i];
			end
			mism[i] = !flags_q[i] && (position_q < code_len_w) &&
				(atrc_pkg::CODE_TEXT[i][pos_idx] != ch);
		end

		phase_n = phase_q;
		flags_n = flags_q;
		found_n = found_q;
		plen_n  = plen_q;

		if (phase_q == PH_MATCH) begin
			if (hit) begin
				found_n = hit_id;
				plen_n  = LW'(position_q);
				phase_n = PH_SKIP;
			end else begin
				flags_n = flags_q | mism;
				if (&flags_n) begin
					found_n = atrc_pkg::CODE_UNKNOWN;
					plen_n  = '0;
					phase_n = PH_TAIL;
				end
			end
		end

		// Count trailing colons and spaces into the prefix.
		if (phase_n == PH_SKIP) begin
			if (ch == atrc_pkg::CH_COLON || ch == atrc_pkg::CH_SPACE) begin
				plen_n = LW'(position_q) + LW'(1);
			end else begin
				phase_n = PH_TAIL;
			end
		end

		res_valid = last;
		if (position_q == '0 && ch == atrc_pkg::CH_NUL) begin
			res.code     = atrc_pkg::CODE_NONE;
			res.code_len = '0;
		end else if (phase_n == PH_MATCH || found_n == atrc_pkg::CODE_UNKNOWN) begin
			res.code     = atrc_pkg::CODE_UNKNOWN;
			res.code_len = '0;
		end else begin
			res.code     = found_n;
			res.code_len = (32'(plen_n) > 32'(atrc_pkg::LEN_MAX)) ?
				7'(atrc_pkg::LEN_MAX) : 7'(plen_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MATCH;
			flags_q    <= '0;
			position_q <= '0;
			found_q    <= atrc_pkg::CODE_NONE;
			plen_q     <= '0;
		end else if (step) begin
			if (last) begin
				phase_q    <= PH_MATCH;
				flags_q    <= '0;
				position_q <= '0;
				found_q    <= atrc_pkg::CODE_NONE;
				plen_q     <= '0;
			end else begin
				phase_q    <= phase_n;
				flags_q    <= flags_n;
				position_q <= position_q + PW'(1);
				found_q    <= found_n;
				plen_q     <= plen_n;
			end
		end
	end

endmodule

// File: rtl/core/at_response_code_matcher_core.sv
// Top level of the AT response code matcher: input register, matcher, result register.
// Depends on atrc_pkg, atrc_match and assert_macros.svh.
//
// Channel   Dir  Word bits (low to high)              Meaning
// s_axis    in   tdata[7:0] ch                        one response character
// m_axis    out  tdata[3:0] code, [10:4] code_len     one result per message
//
// One character is taken per cycle, back to back, for as long as the result side keeps up.
// A result passes from the input register to the result register: the compare and update
// logic works on the word in the input register and loads the result register when that word
// advances, which a stall on the result side can hold back.
// Reset (arst_n low) clears all valid flags and the matcher state; the next word starts a message.
// While m_axis_tready is low the result register holds; the input register takes one more
// word, then s_axis_tready drops until the result is taken.
`include "assert_macros.svh"

module at_response_code_matcher_core #(
	parameter int unsigned BUF_LEN = atrc_pkg::BUF_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] ch
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [3:0] code, [10:4] code_len, [15:11] zero
);

	logic                   in_valid_s1;
	logic [7:0]             ch_s1;
	logic                   advance;
	logic                   res_valid;
	atrc_pkg::atrc_result_t res;
	logic                   out_valid_q;
	atrc_pkg::atrc_result_t out_q;
	logic                   out_no_code;

	// Move the held character into the matcher whenever the result slot is free or draining.
	assign advance       = in_valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !in_valid_s1 || advance;

	// Input register: load on accept, drop once consumed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			ch_s1 <= s_axis_tdata;
		end
	end

	atrc_match #(
		.BUF_LEN(BUF_LEN)
	) u_match (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.ch       (ch_s1),
		.res_valid(res_valid),
		.res      (res)
	);

	// Result register: load when a message ends, hold while stalled, clear when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b0, out_q.code_len, out_q.code};

	assign out_no_code = (out_q.code == atrc_pkg::CODE_NONE) ||
		(out_q.code == atrc_pkg::CODE_UNKNOWN);

	`ASSERT_IMPL(a_len_zero_no_code, out_valid_q && out_no_code, out_q.code_len == 7'd0, "length set")
	`ASSERT_IMPL(a_code_range, out_valid_q, out_q.code <= atrc_pkg::CODE_LAST, "code out of range")
	`ASSERT_NEXT(a_in_hold, in_valid_s1 && !advance, in_valid_s1 && $stable(ch_s1), "held word lost")

endmodule
